FILE: hdl/tfrgba_pkg.sv
// shared types, format codes and channel widening functions for the texel unpacker
package tfrgba_pkg;

  typedef enum logic [3:0] {
    FMT_ARGB8888 = 4'd0,
    FMT_XRGB8888 = 4'd1,
    FMT_RGB888   = 4'd2,
    FMT_RGB565   = 4'd3,
    FMT_ARGB1555 = 4'd4,
    FMT_ARGB4444 = 4'd5,
    FMT_A8       = 4'd6,
    FMT_L8       = 4'd7,
    FMT_A8L8     = 4'd8,
    FMT_A4L4     = 4'd9
  } fmt_t;

  localparam logic [7:0] CHAN_FULL = 8'hFF;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // bit replication up to 8 bits
  function automatic logic [7:0] widen4(input logic [3:0] v);
    widen4 = {v, v};
  endfunction

  function automatic logic [7:0] widen5(input logic [4:0] v);
    widen5 = {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    widen6 = {v, v[5:4]};
  endfunction

endpackage

FILE: hdl/tfrgba_decode.sv
// combinational texel decoder: raw word and format code to rgba8
module tfrgba_decode (
  input  logic [31:0]       pixel_word,
  input  tfrgba_pkg::fmt_t  fmt,
  output tfrgba_pkg::rgba_t rgba
);

  logic [7:0]  b0, b1, b2, b3;
  logic [15:0] w;

  assign b0 = pixel_word[7:0];
  assign b1 = pixel_word[15:8];
  assign b2 = pixel_word[23:16];
  assign b3 = pixel_word[31:24];
  assign w  = pixel_word[15:0];

  always_comb begin
    rgba.red   = tfrgba_pkg::CHAN_FULL;
    rgba.green = tfrgba_pkg::CHAN_FULL;
    rgba.blue  = tfrgba_pkg::CHAN_FULL;
    rgba.alpha = tfrgba_pkg::CHAN_FULL;
    case (fmt)
      tfrgba_pkg::FMT_ARGB8888: begin
        rgba.red   = b2;
        rgba.green = b1;
        rgba.blue  = b0;
        rgba.alpha = b3;
      end
      tfrgba_pkg::FMT_XRGB8888, tfrgba_pkg::FMT_RGB888: begin
        rgba.red   = b2;
        rgba.green = b1;
        rgba.blue  = b0;
      end
      tfrgba_pkg::FMT_RGB565: begin
        rgba.red   = tfrgba_pkg::widen5(w[15:11]);
        rgba.green = tfrgba_pkg::widen6(w[10:5]);
        rgba.blue  = tfrgba_pkg::widen5(w[4:0]);
      end
      tfrgba_pkg::FMT_ARGB1555: begin
        rgba.red   = tfrgba_pkg::widen5(w[14:10]);
        rgba.green = tfrgba_pkg::widen5(w[9:5]);
        rgba.blue  = tfrgba_pkg::widen5(w[4:0]);
        rgba.alpha = {8{w[15]}};
      end
      tfrgba_pkg::FMT_ARGB4444: begin
        rgba.red   = tfrgba_pkg::widen4(w[11:8]);
        rgba.green = tfrgba_pkg::widen4(w[7:4]);
        rgba.blue  = tfrgba_pkg::widen4(w[3:0]);
        rgba.alpha = tfrgba_pkg::widen4(w[15:12]);
      end
      tfrgba_pkg::FMT_A8: begin
        rgba.alpha = b0;
      end
      tfrgba_pkg::FMT_L8: begin
        rgba.red   = b0;
        rgba.green = b0;
        rgba.blue  = b0;
      end
      tfrgba_pkg::FMT_A8L8: begin
        rgba.red   = b0;
        rgba.green = b0;
        rgba.blue  = b0;
        rgba.alpha = b1;
      end
      tfrgba_pkg::FMT_A4L4: begin
        rgba.red   = tfrgba_pkg::widen4(b0[3:0]);
        rgba.green = tfrgba_pkg::widen4(b0[3:0]);
        rgba.blue  = tfrgba_pkg::widen4(b0[3:0]);
        rgba.alpha = tfrgba_pkg::widen4(b0[7:4]);
      end
      default: begin
        // unsupported codes give opaque white
        rgba.red   = tfrgba_pkg::CHAN_FULL;
        rgba.green = tfrgba_pkg::CHAN_FULL;
        rgba.blue  = tfrgba_pkg::CHAN_FULL;
        rgba.alpha = tfrgba_pkg::CHAN_FULL;
      end
    endcase
  end

endmodule

FILE: hdl/texel_format_to_rgba8.sv
// top level of the texel unpacker: raw texel words in, rgba8 results out
//
// Unpacks one raw texel (up to four little-endian bytes, byte 0 in bits 7:0)
// into 8-bit red, green, blue and alpha, one result per input transfer. The
// source format comes from cfg_pixel_format, written when cfg_wr_en is high:
// 0 ARGB8888, 1 XRGB8888, 2 RGB888, 3 RGB565, 4 ARGB1555, 5 ARGB4444, 6 A8,
// 7 L8, 8 A8L8, 9 A4L4; codes 10 to 15 give opaque white. Narrow channels
// widen by bit replication and channels that a format lacks read 255. Reset
// selects ARGB8888. Change the format only while no transfer is in flight.
// The datapath is two registers deep: an input register, the decode mux, and
// a result register. An input transfer loads the input register, and the
// decoded result then enters the result register, from which it leaves as a
// result transfer. The block sustains one texel per clock while out_stall is
// low; with both registers full, a stall on the result side backs up into
// in_stall in the same cycle without dropping data.
module texel_format_to_rgba8 (
  input  logic        clk,
  input  logic        rst_n,

  // configuration
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_pixel_format,

  // texel input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_pixel_word,

  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha
);

  // format register
  tfrgba_pkg::fmt_t  fmt_r;

  // input stage
  logic              in_vld_r;
  logic [31:0]       word_r;

  // result stage
  logic              out_vld_r;
  tfrgba_pkg::rgba_t rgba_r;
  tfrgba_pkg::rgba_t rgba_nxt;

  logic              out_load;
  logic              in_load;

  // result register takes a new texel when empty or when its result leaves
  assign out_load = !out_vld_r || !out_stall;
  // input register takes a new word when empty or when it moves forward
  assign in_load  = !in_vld_r || out_load;
  assign in_stall = !in_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= tfrgba_pkg::FMT_ARGB8888;
    end else if (cfg_wr_en) begin
      fmt_r <= tfrgba_pkg::fmt_t'(cfg_pixel_format);
    end
  end

  // input stage control and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_load) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      word_r <= in_pixel_word;
    end
  end

  // decode between the two registers
  tfrgba_decode u_decode (
    .pixel_word (word_r),
    .fmt        (fmt_r),
    .rgba       (rgba_nxt)
  );

  // result stage control and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_vld_r) begin
      rgba_r <= rgba_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_red   = rgba_r.red;
  assign out_green = rgba_r.green;
  assign out_blue  = rgba_r.blue;
  assign out_alpha = rgba_r.alpha;

endmodule
